// ===== design/circular_ring_with_cursor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin ring
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_RING_WITH_CURSOR_ASSERT_SVH
`define CIRCULAR_RING_WITH_CURSOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRWC_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("Ring invariant violated in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define CRWC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("Ring invariant violated in the following cycle.");

`endif

// ===== design/crwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin ring package
// Widths, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package crwc_pkg;

   // Entry index width is a package constant; every index is an entry.
   localparam int NODE_W  = 4;
   localparam int ENTRIES = 1 << NODE_W;

   typedef enum logic [1:0] {
      CMD_ADD         = 2'd0,
      CMD_ADVANCE     = 2'd1,
      CMD_REMOVE_CUR  = 2'd2,
      CMD_REMOVE_NODE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_CONFLICT = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic link;
      logic load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_link;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== design/crwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Round-robin ring controller
// Sequences one command through read, execute, optional link and load steps.
// ----------------------------------------------------------------------------
module crwc_ctrl
   import crwc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_stat,
   output ctl_cmd_type   ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LINK,
      S_LOAD
   } state_type;

   state_type state_ff;

   // A new command is taken only when no earlier one is still in flight.
   assign req_stall  = (state_ff != S_IDLE);
   assign ctl.accept = req_valid && (state_ff == S_IDLE);
   assign ctl.exec   = (state_ff == S_EXEC);
   assign ctl.link   = (state_ff == S_LINK);
   assign ctl.load   = (state_ff == S_LOAD) && dp_stat.rsp_free;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= dp_stat.need_link ? S_LINK : S_LOAD;
            end
            S_LINK: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (dp_stat.rsp_free) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/crwc_datapath.sv =====
// ----------------------------------------------------------------------------
// Round-robin ring datapath
// Link tables, membership bits, cursor, and the result register.
// ----------------------------------------------------------------------------
`include "circular_ring_with_cursor_assert.svh"

module crwc_datapath
   import crwc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         ctl,
   output dp_status_type       dp_stat,
   input  logic [1:0]          req_cmd,
   input  logic [NODE_W-1:0]   req_node_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic                rsp_returned_valid,
   output logic [NODE_W-1:0]   rsp_returned_node,
   output logic [NODE_W-1:0]   rsp_cursor_after,
   output logic                rsp_ring_is_empty
);

   // Link tables: one write and one registered read per cycle each.
   logic [NODE_W-1:0] succ_mem [ENTRIES];
   logic [NODE_W-1:0] pred_mem [ENTRIES];

   logic [ENTRIES-1:0] member_ff;
   logic [NODE_W-1:0]  cursor_ff;
   logic               empty_ff;

   cmd_type            cmd_ff;
   logic [NODE_W-1:0]  node_ff;
   logic [NODE_W-1:0]  succ_rd_ff;
   logic [NODE_W-1:0]  pred_rd_ff;
   logic [NODE_W-1:0]  link_p_ff;

   status_type         pend_status_ff;
   logic               pend_rvalid_ff;
   logic [NODE_W-1:0]  pend_rnode_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_rvalid_ff;
   logic [NODE_W-1:0]  rsp_rnode_ff;
   logic [NODE_W-1:0]  rsp_cursor_ff;
   logic               rsp_empty_ff;

   logic [NODE_W-1:0]  rd_addr;
   logic               is_current;
   logic               sole_member;

   status_type         ex_status;
   logic               ex_rvalid;
   logic [NODE_W-1:0]  ex_rnode;
   logic               ex_sw_en;
   logic [NODE_W-1:0]  ex_sw_addr;
   logic [NODE_W-1:0]  ex_sw_data;
   logic               ex_pw_en;
   logic [NODE_W-1:0]  ex_pw_addr;
   logic [NODE_W-1:0]  ex_pw_data;
   logic               ex_mem_set;
   logic               ex_mem_clr;
   logic [NODE_W-1:0]  ex_mem_addr;
   logic               ex_cursor_wr;
   logic [NODE_W-1:0]  ex_cursor_in;
   logic               ex_empty_wr;
   logic               ex_empty_in;
   logic               ex_need_link;

   logic               sw_en;
   logic [NODE_W-1:0]  sw_addr;
   logic [NODE_W-1:0]  sw_data;
   logic               pw_en;
   logic [NODE_W-1:0]  pw_addr;
   logic [NODE_W-1:0]  pw_data;

   // Named removes look up the named entry; everything else the cursor.
   assign rd_addr = (cmd_type'(req_cmd) == CMD_REMOVE_NODE) ? req_node_index : cursor_ff;

   // Capture the command and read the links of the entry it concerns.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff     <= cmd_type'(req_cmd);
         node_ff    <= req_node_index;
         succ_rd_ff <= succ_mem[rd_addr];
         pred_rd_ff <= pred_mem[rd_addr];
      end
   end

   assign is_current  = (cmd_ff == CMD_REMOVE_CUR) ||
                        ((cmd_ff == CMD_REMOVE_NODE) && (node_ff == cursor_ff));
   assign sole_member = (succ_rd_ff == cursor_ff);

   // Execute step: decide the result and the table updates.
   always_comb begin
      ex_status    = STATUS_DONE;
      ex_rvalid    = 1'b0;
      ex_rnode     = '0;
      ex_sw_en     = 1'b0;
      ex_sw_addr   = node_ff;
      ex_sw_data   = node_ff;
      ex_pw_en     = 1'b0;
      ex_pw_addr   = node_ff;
      ex_pw_data   = node_ff;
      ex_mem_set   = 1'b0;
      ex_mem_clr   = 1'b0;
      ex_mem_addr  = node_ff;
      ex_cursor_wr = 1'b0;
      ex_cursor_in = cursor_ff;
      ex_empty_wr  = 1'b0;
      ex_empty_in  = empty_ff;
      ex_need_link = 1'b0;
      if (cmd_ff == CMD_ADD) begin
         if (member_ff[node_ff]) begin
            ex_status = STATUS_CONFLICT;
         end else if (empty_ff) begin
            // First member links to itself and becomes the cursor.
            ex_sw_en     = 1'b1;
            ex_pw_en     = 1'b1;
            ex_mem_set   = 1'b1;
            ex_cursor_wr = 1'b1;
            ex_cursor_in = node_ff;
            ex_empty_wr  = 1'b1;
            ex_empty_in  = 1'b0;
         end else begin
            // New entry points at the cursor and its old predecessor.
            ex_sw_en     = 1'b1;
            ex_sw_data   = cursor_ff;
            ex_pw_en     = 1'b1;
            ex_pw_data   = pred_rd_ff;
            ex_mem_set   = 1'b1;
            ex_need_link = 1'b1;
         end
      end else if (empty_ff) begin
         ex_status = STATUS_EMPTY;
      end else if (cmd_ff == CMD_ADVANCE) begin
         ex_cursor_wr = 1'b1;
         ex_cursor_in = succ_rd_ff;
         ex_rvalid    = 1'b1;
         ex_rnode     = succ_rd_ff;
      end else if (is_current) begin
         ex_rvalid    = 1'b1;
         ex_rnode     = cursor_ff;
         ex_mem_clr   = 1'b1;
         ex_mem_addr  = cursor_ff;
         ex_cursor_wr = 1'b1;
         if (sole_member) begin
            ex_cursor_in = '0;
            ex_empty_wr  = 1'b1;
            ex_empty_in  = 1'b1;
         end else begin
            ex_cursor_in = pred_rd_ff;
            ex_sw_en     = 1'b1;
            ex_sw_addr   = pred_rd_ff;
            ex_sw_data   = succ_rd_ff;
            ex_pw_en     = 1'b1;
            ex_pw_addr   = succ_rd_ff;
            ex_pw_data   = pred_rd_ff;
         end
      end else if (!member_ff[node_ff]) begin
         ex_status = STATUS_CONFLICT;
      end else begin
         ex_rvalid  = 1'b1;
         ex_rnode   = node_ff;
         ex_mem_clr = 1'b1;
         ex_sw_en   = 1'b1;
         ex_sw_addr = pred_rd_ff;
         ex_sw_data = succ_rd_ff;
         ex_pw_en   = 1'b1;
         ex_pw_addr = succ_rd_ff;
         ex_pw_data = pred_rd_ff;
      end
   end

   assign dp_stat.need_link = ex_need_link;
   assign dp_stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Table write port selection: the link step closes the ring around a new entry.
   always_comb begin
      sw_en   = 1'b0;
      sw_addr = ex_sw_addr;
      sw_data = ex_sw_data;
      pw_en   = 1'b0;
      pw_addr = ex_pw_addr;
      pw_data = ex_pw_data;
      if (ctl.link) begin
         sw_en   = 1'b1;
         sw_addr = link_p_ff;
         sw_data = node_ff;
         pw_en   = 1'b1;
         pw_addr = cursor_ff;
         pw_data = node_ff;
      end else if (ctl.exec) begin
         sw_en = ex_sw_en;
         pw_en = ex_pw_en;
      end
   end

   // Link table writes.
   always_ff @(posedge clock) begin
      if (sw_en) succ_mem[sw_addr] <= sw_data;
      if (pw_en) pred_mem[pw_addr] <= pw_data;
   end

   // Ring control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff <= '0;
         cursor_ff <= '0;
         empty_ff  <= 1'b1;
      end else if (ctl.exec) begin
         if (ex_mem_set) member_ff[ex_mem_addr] <= 1'b1;
         if (ex_mem_clr) member_ff[ex_mem_addr] <= 1'b0;
         if (ex_cursor_wr) cursor_ff <= ex_cursor_in;
         if (ex_empty_wr) empty_ff <= ex_empty_in;
      end
   end

   // Pending result and the predecessor kept for the link step.
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         pend_status_ff <= ex_status;
         pend_rvalid_ff <= ex_rvalid;
         pend_rnode_ff  <= ex_rnode;
         link_p_ff      <= pred_rd_ff;
      end
   end

   // Result register: holds a transfer until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_rvalid_ff <= pend_rvalid_ff;
         rsp_rnode_ff  <= pend_rnode_ff;
         rsp_cursor_ff <= empty_ff ? '0 : cursor_ff;
         rsp_empty_ff  <= empty_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_returned_valid = rsp_rvalid_ff;
   assign rsp_returned_node  = rsp_rnode_ff;
   assign rsp_cursor_after   = rsp_cursor_ff;
   assign rsp_ring_is_empty  = rsp_empty_ff;

   // An empty ring has no members, and a non-empty ring's cursor is a member.
   `CRWC_ASSERT_IMPLIES(a_empty_no_members, empty_ff, member_ff == '0)
   `CRWC_ASSERT_IMPLIES(a_cursor_is_member, !empty_ff, member_ff[cursor_ff])
   // A successful add leaves the entry marked as a member.
   `CRWC_ASSERT_NEXT(a_add_sets_member, ctl.exec && ex_mem_set, member_ff[node_ff])
   // An add into a non-empty ring is always followed by the link step.
   `CRWC_ASSERT_NEXT(a_link_after_add, ctl.exec && ex_need_link, ctl.link)

endmodule

// ===== design/circular_ring_with_cursor.sv =====
// ----------------------------------------------------------------------------
// Round-robin ring with cursor
// Top level: controller and datapath for a linked ring of entry indices.
// ----------------------------------------------------------------------------
// A command is taken when req_valid is high and req_stall is low, and yields
// exactly one result transfer on the rsp_ channel. Each command passes
// through accept with table read, execute and load steps, and the result is
// registered in the load step; an add into a non-empty ring adds a link step
// between execute and load, because it writes two extra links. The steps are
// set by the link tables, which have one write port and one registered read
// port each. A finished result waits in the output register while the next
// command is accepted; that next command then holds in its load step until
// the result is taken. No clearing pass is needed after reset: membership
// bits are cleared at once and only member links are ever used.
module circular_ring_with_cursor
   import crwc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [NODE_W-1:0] req_node_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic              rsp_returned_valid,
   output logic [NODE_W-1:0] rsp_returned_node,
   output logic [NODE_W-1:0] rsp_cursor_after,
   output logic              rsp_ring_is_empty
);

   ctl_cmd_type   ctl;
   dp_status_type dp_stat;

   // Command sequencer.
   crwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .ctl       (ctl)
   );

   // Tables, ring state and result register.
   crwc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .dp_stat            (dp_stat),
      .req_cmd            (req_cmd),
      .req_node_index     (req_node_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_returned_valid (rsp_returned_valid),
      .rsp_returned_node  (rsp_returned_node),
      .rsp_cursor_after   (rsp_cursor_after),
      .rsp_ring_is_empty  (rsp_ring_is_empty)
   );

endmodule
